FILE: rtl/core/sha256_round_coordinate_hash_assert.svh
// assertion macros for the coordinate hash
`ifndef SHA256_ROUND_COORDINATE_HASH_ASSERT_SVH
`define SHA256_ROUND_COORDINATE_HASH_ASSERT_SVH

// implication checked every clock outside reset
`define SRCH_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// implication checked on the next clock
`define SRCH_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

FILE: rtl/core/srch_pkg.sv
package srch_pkg;

  localparam int unsigned Rounds = 64;
  localparam int unsigned RndW   = 6;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } state_t;

  localparam state_t InitState = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t v, int unsigned s);
    rotr = (v >> s) | (v << (32 - s));
  endfunction

  function automatic word_t swap32(word_t v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

FILE: rtl/core/srch_msg_cell.sv
// one word of the 16-word message window
module srch_msg_cell (
  input  logic            clk,
  input  logic            load,
  input  logic            shift,
  input  srch_pkg::word_t load_word,
  input  srch_pkg::word_t shift_in,
  output srch_pkg::word_t word_q
);

  srch_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= load_word;
    end else if (shift) begin
      word_r <= shift_in;
    end
  end

  assign word_q = word_r;

endmodule

FILE: rtl/core/srch_round.sv
// one compression round on the working words
module srch_round (
  input  srch_pkg::state_t s,
  input  srch_pkg::word_t  k,
  input  srch_pkg::word_t  w,
  output srch_pkg::state_t s_nxt
);

  srch_pkg::word_t big1, ch, t1, big0, maj, t2;

  always_comb begin
    big1 = srch_pkg::rotr(s.e, 6) ^ srch_pkg::rotr(s.e, 11) ^ srch_pkg::rotr(s.e, 25);
    ch   = s.g ^ (s.e & (s.f ^ s.g));
    t1   = s.h + big1 + ch + k + w;
    big0 = srch_pkg::rotr(s.a, 2) ^ srch_pkg::rotr(s.a, 13) ^ srch_pkg::rotr(s.a, 22);
    maj  = (s.a & s.b) | (s.c & (s.a | s.b));
    t2   = big0 + maj;
    s_nxt.h = s.g;
    s_nxt.g = s.f;
    s_nxt.f = s.e;
    s_nxt.e = s.d + t1;
    s_nxt.d = s.c;
    s_nxt.c = s.b;
    s_nxt.b = s.a;
    s_nxt.a = t1 + t2;
  end

endmodule

FILE: rtl/core/sha256_round_coordinate_hash.sv
// an input beat runs through the rounds in S_RUN, then S_DONE copies the state into the output register
// a new item is accepted only in S_IDLE; the single round unit does one round a cycle
// the next item is taken while the previous result waits in the output register
// reset: rst_n synchronous active low, clears control and seed_r to zero
module sha256_round_coordinate_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_extra_param,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word_a,
  output logic [31:0] out_word_b,
  output logic [31:0] out_word_c,
  output logic [31:0] out_word_d,
  output logic [31:0] out_word_e,
  output logic [31:0] out_word_f,
  output logic [31:0] out_word_g,
  output logic [31:0] out_word_h,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} fsm_t;

  fsm_t                           st_r;
  logic [srch_pkg::RndW-1:0]      rnd_r;
  srch_pkg::word_t                seed_r;
  srch_pkg::state_t               v_r, v_nxt, res_r;
  logic                           ov_r;
  logic                           load, shift;
  srch_pkg::word_t                win [16];
  srch_pkg::word_t                ld [16];
  srch_pkg::word_t                s0, s1, w_new;

  assign in_ready = (st_r == S_IDLE);
  assign load     = in_valid && in_ready;
  assign shift    = (st_r == S_RUN);

  always_comb begin
    for (int i = 0; i < 16; i++) ld[i] = '0;
    ld[0] = srch_pkg::swap32(in_coord_x);
    ld[1] = srch_pkg::swap32(in_coord_y);
    ld[2] = srch_pkg::swap32(seed_r);
    ld[3] = srch_pkg::swap32(in_extra_param);
    s0 = srch_pkg::rotr(win[1], 7) ^ srch_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = srch_pkg::rotr(win[14], 17) ^ srch_pkg::rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = win[0] + s0 + win[9] + s1;
  end

  for (genvar g = 0; g < 16; g++) begin : g_win
    if (g == 15) begin : g_tail
      srch_msg_cell u_cell (
        .clk(clk), .load(load), .shift(shift), .load_word(ld[g]),
        .shift_in(w_new), .word_q(win[g])
      );
    end else begin : g_body
      srch_msg_cell u_cell (
        .clk(clk), .load(load), .shift(shift), .load_word(ld[g]),
        .shift_in(win[g+1]), .word_q(win[g])
      );
    end
  end

  srch_round u_round (
    .s(v_r), .k(srch_pkg::RoundK[rnd_r]), .w(win[0]), .s_nxt(v_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      rnd_r  <= '0;
      seed_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      if (out_valid && out_ready && (st_r != S_DONE)) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (load) begin
            v_r   <= srch_pkg::InitState;
            rnd_r <= '0;
            st_r  <= S_RUN;
          end
        end
        S_RUN: begin
          v_r   <= v_nxt;
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == srch_pkg::RndW'(srch_pkg::Rounds - 1)) begin
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov_r || out_ready) begin
            res_r <= v_r;
            ov_r  <= 1'b1;
            st_r  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = ov_r;
  assign out_word_a = res_r.a;
  assign out_word_b = res_r.b;
  assign out_word_c = res_r.c;
  assign out_word_d = res_r.d;
  assign out_word_e = res_r.e;
  assign out_word_f = res_r.f;
  assign out_word_g = res_r.g;
  assign out_word_h = res_r.h;

endmodule

FILE: rtl/core/srch_checker.sv
`include "sha256_round_coordinate_hash_assert.svh"

module srch_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word_a
);

  // stalled result beat keeps its payload
  `SRCH_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && !out_ready, out_valid && $stable(out_word_a),
    "result beat dropped or changed while stalled")
  // an accepted item blocks the input while rounds run
  `SRCH_ASSERT_NEXT(a_busy, clk, rst_n,
    in_valid && in_ready, !in_ready,
    "input accepted during rounds")
  // no result appears right after an input beat
  `SRCH_ASSERT_IMP(a_no_early, clk, rst_n,
    $past(in_valid && in_ready) && !$past(out_valid), !out_valid,
    "result too early")

endmodule

bind sha256_round_coordinate_hash srch_checker u_srch_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word_a(out_word_a)
);
